FILE: src/sts_pkg.sv
// package with token codes, scan modes, error codes and size constants for the token scanner
package sts_pkg;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_WORD      = 4'd1,
    M_WHOLE     = 4'd2,
    M_WHOLE_DOT = 4'd3,
    M_FRACTION  = 4'd4,
    M_QUOTED    = 4'd5,
    M_OPER      = 4'd6,
    M_COMMENT   = 4'd7,
    M_TICK      = 4'd8,
    M_TICK_BYTE = 4'd9
  } mode_t;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_SEMI = 6'd4;
  localparam logic [5:0] K_COMMA = 6'd5;
  localparam logic [5:0] K_DOT = 6'd6;
  localparam logic [5:0] K_MINUS = 6'd7;
  localparam logic [5:0] K_PLUS = 6'd8;
  localparam logic [5:0] K_SLASH = 6'd9;
  localparam logic [5:0] K_STAR = 6'd10;
  localparam logic [5:0] K_REF = 6'd11;
  localparam logic [5:0] K_AND = 6'd12;
  localparam logic [5:0] K_OR = 6'd13;
  localparam logic [5:0] K_BANG = 6'd14;
  localparam logic [5:0] K_BANG_EQ = 6'd15;
  localparam logic [5:0] K_EQ = 6'd16;
  localparam logic [5:0] K_EQ_EQ = 6'd17;
  localparam logic [5:0] K_LT = 6'd18;
  localparam logic [5:0] K_LT_EQ = 6'd19;
  localparam logic [5:0] K_GT = 6'd20;
  localparam logic [5:0] K_GT_EQ = 6'd21;
  localparam logic [5:0] K_STRING = 6'd22;
  localparam logic [5:0] K_CHARLIT = 6'd23;
  localparam logic [5:0] K_INTEGER = 6'd24;
  localparam logic [5:0] K_DECIMAL = 6'd25;
  localparam logic [5:0] K_IDENT = 6'd26;
  localparam logic [5:0] K_BOOL = 6'd27;
  localparam logic [5:0] K_CHAR = 6'd28;
  localparam logic [5:0] K_DOUBLE = 6'd29;
  localparam logic [5:0] K_ELSE = 6'd30;
  localparam logic [5:0] K_FALSE = 6'd31;
  localparam logic [5:0] K_FOR = 6'd32;
  localparam logic [5:0] K_IF = 6'd33;
  localparam logic [5:0] K_INT = 6'd34;
  localparam logic [5:0] K_NULL = 6'd35;
  localparam logic [5:0] K_PRINT = 6'd36;
  localparam logic [5:0] K_RETURN = 6'd37;
  localparam logic [5:0] K_STR = 6'd38;
  localparam logic [5:0] K_STRUCT = 6'd39;
  localparam logic [5:0] K_TRUE = 6'd40;
  localparam logic [5:0] K_VOID = 6'd41;
  localparam logic [5:0] K_WHILE = 6'd42;
  localparam logic [5:0] K_ERROR = 6'd43;
  localparam logic [5:0] K_END = 6'd44;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNTERM = 2'd1;
  localparam logic [1:0] E_NO_CLOSE = 2'd2;
  localparam logic [1:0] E_UNEXPECTED = 2'd3;

  localparam int PREFIX_N = 6;
  localparam int MAX_TOKENS = 3;
  localparam int QUEUE_DEPTH = 4;

endpackage

FILE: src/source_token_scanner_unit.sv
// top level of the streaming token scanner: byte in, up to three token beats out
// a token is written into the output queue as the byte that completes it is accepted, and leaves in order
// throughput: one source byte per cycle while ready_in is high; each byte makes up to three result beats,
// which drain from a four-entry output queue at one beat per cycle while ready_out is high
// input ready falls while the queue lacks room for three more beats
// reset (rst, synchronous, active high): idle mode, offsets zero, line one, queue empty
module source_token_scanner_unit #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  output logic                   ready_in,
  input  logic [7:0]             source_byte,
  output logic                   valid_out,
  input  logic                   ready_out,
  output logic [5:0]             token_kind,
  output logic [OFFSET_BITS-1:0] token_start,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]   line_number,
  output logic [1:0]             error_code,
  output logic                   last_of_run
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  typedef struct packed {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [1:0]             err;
    logic                   last;
  } tok_t;

  // scanner state
  sts_pkg::mode_t           mode, mode_next;
  logic [7:0]               look, look_next;
  logic [OFFSET_BITS-1:0]   tstart, tstart_next;
  logic [OFFSET_BITS-1:0]   offset, offset_next;
  logic [LINE_BITS-1:0]     line, line_next;
  logic [LENGTH_BITS-1:0]   length, length_next;
  logic [7:0]               prefix [sts_pkg::PREFIX_N];
  logic                     pfx_we;
  logic [2:0]               pfx_addr;

  // output queue: four entries, two-bit pointers and a separate occupancy count
  tok_t     queue [sts_pkg::QUEUE_DEPTH];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  // tokens made by the current byte
  tok_t       tok [sts_pkg::MAX_TOKENS];
  logic [1:0] ntok;

  logic accept_in, accept_out;
  assign accept_in  = valid_in && ready_in;
  assign accept_out = valid_out && ready_out;
  assign ready_in   = (count <= 3'd1);
  assign valid_out  = (count != 3'd0);

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // keyword match against the stored prefix and length
  logic [5:0] wkind;
  always_comb begin
    logic [LENGTH_BITS-1:0] n;
    n = length;
    wkind = sts_pkg::K_IDENT;
    if (n <= LENGTH_BITS'(sts_pkg::PREFIX_N)) begin
      case (prefix[0])
        "b": if (n == 4 && prefix[1] == "o" && prefix[2] == "o" && prefix[3] == "l")
          wkind = sts_pkg::K_BOOL;
        "c": if (n == 4 && prefix[1] == "h" && prefix[2] == "a" && prefix[3] == "r")
          wkind = sts_pkg::K_CHAR;
        "d": if (n == 6 && prefix[1] == "o" && prefix[2] == "u" && prefix[3] == "b"
                 && prefix[4] == "l" && prefix[5] == "e")
          wkind = sts_pkg::K_DOUBLE;
        "e": if (n == 4 && prefix[1] == "l" && prefix[2] == "s" && prefix[3] == "e")
          wkind = sts_pkg::K_ELSE;
        "f": begin
          if (n == 5 && prefix[1] == "a" && prefix[2] == "l" && prefix[3] == "s"
              && prefix[4] == "e")
            wkind = sts_pkg::K_FALSE;
          else if (n == 3 && prefix[1] == "o" && prefix[2] == "r")
            wkind = sts_pkg::K_FOR;
          else if (n == 3 && prefix[1] == "u" && prefix[2] == "n")
            wkind = sts_pkg::K_VOID;
        end
        "i": begin
          if (n == 2 && prefix[1] == "f") wkind = sts_pkg::K_IF;
          else if (n == 3 && prefix[1] == "n" && prefix[2] == "t") wkind = sts_pkg::K_INT;
        end
        "n": if (n == 4 && prefix[1] == "u" && prefix[2] == "l" && prefix[3] == "l")
          wkind = sts_pkg::K_NULL;
        "p": if (n == 5 && prefix[1] == "r" && prefix[2] == "i" && prefix[3] == "n"
                 && prefix[4] == "t")
          wkind = sts_pkg::K_PRINT;
        "r": if (n == 3 && prefix[1] == "e" && prefix[2] == "t")
          wkind = sts_pkg::K_RETURN;
        "s": begin
          if (n == 3 && prefix[1] == "t" && prefix[2] == "r") wkind = sts_pkg::K_STR;
          else if (n == 6 && prefix[1] == "t" && prefix[2] == "r" && prefix[3] == "u"
                   && prefix[4] == "c" && prefix[5] == "t")
            wkind = sts_pkg::K_STRUCT;
        end
        "t": if (n == 4 && prefix[1] == "r" && prefix[2] == "u" && prefix[3] == "e")
          wkind = sts_pkg::K_TRUE;
        "v": if (n == 4 && prefix[1] == "o" && prefix[2] == "i" && prefix[3] == "d")
          wkind = sts_pkg::K_VOID;
        "w": if (n == 5 && prefix[1] == "h" && prefix[2] == "i" && prefix[3] == "l"
                 && prefix[4] == "e")
          wkind = sts_pkg::K_WHILE;
        default: wkind = sts_pkg::K_IDENT;
      endcase
    end
  end

  // main per-byte decode: finishing step, then a fresh scan when the byte is not used
  always_comb begin
    logic [7:0]             c;
    logic                   used, ended;
    logic [LENGTH_BITS-1:0] inc1, inc2;
    tok_t                   t;
    c = source_byte;
    used = 1'b0;
    ended = 1'b0;
    inc1 = (length == LEN_MAX) ? LEN_MAX : length + LENGTH_BITS'(1);
    inc2 = (length >= LEN_MAX - LENGTH_BITS'(1)) ? LEN_MAX : length + LENGTH_BITS'(2);
    mode_next   = mode;
    look_next   = look;
    tstart_next = tstart;
    length_next = length;
    line_next   = line;
    pfx_we      = 1'b0;
    pfx_addr    = 3'd0;
    ntok        = 2'd0;
    t           = '0;
    for (int k = 0; k < sts_pkg::MAX_TOKENS; k++) tok[k] = '0;

    case (mode)
      sts_pkg::M_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          if (length < LENGTH_BITS'(sts_pkg::PREFIX_N)) begin
            pfx_we = 1'b1;
            pfx_addr = length[2:0];
          end
          length_next = inc1;
          used = 1'b1;
        end else begin
          tok[0] = '{wkind, tstart, length, line, sts_pkg::E_NONE, 1'b0};
          ntok = 2'd1;
        end
      end
      sts_pkg::M_WHOLE: begin
        if (is_digit(c)) begin
          length_next = inc1; used = 1'b1;
        end else if (c == ".") begin
          mode_next = sts_pkg::M_WHOLE_DOT; used = 1'b1;
        end else begin
          tok[0] = '{sts_pkg::K_INTEGER, tstart, length, line, sts_pkg::E_NONE, 1'b0};
          ntok = 2'd1;
        end
      end
      sts_pkg::M_WHOLE_DOT: begin
        if (is_digit(c)) begin
          length_next = inc2; mode_next = sts_pkg::M_FRACTION; used = 1'b1;
        end else begin
          tok[0] = '{sts_pkg::K_INTEGER, tstart, length, line, sts_pkg::E_NONE, 1'b0};
          tok[1] = '{sts_pkg::K_DOT, offset - OFFSET_BITS'(1), LENGTH_BITS'(1), line,
                     sts_pkg::E_NONE, 1'b0};
          ntok = 2'd2;
        end
      end
      sts_pkg::M_FRACTION: begin
        if (is_digit(c)) begin
          length_next = inc1; used = 1'b1;
        end else begin
          tok[0] = '{sts_pkg::K_DECIMAL, tstart, length, line, sts_pkg::E_NONE, 1'b0};
          ntok = 2'd1;
        end
      end
      sts_pkg::M_QUOTED: begin
        if (c == 8'd0) begin
          tok[0] = '{sts_pkg::K_ERROR, tstart, length, line, sts_pkg::E_UNTERM, 1'b0};
          ntok = 2'd1;
        end else begin
          length_next = inc1;
          used = 1'b1;
          if (c == "\"") begin
            tok[0] = '{sts_pkg::K_STRING, tstart, inc1, line, sts_pkg::E_NONE, 1'b0};
            ntok = 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else if (c == 8'h0a && line < LINE_MAX) begin
            line_next = line + LINE_ONE;
          end
        end
      end
      sts_pkg::M_OPER: begin
        t = '{sts_pkg::K_GT, tstart, LENGTH_BITS'(1), line, sts_pkg::E_NONE, 1'b0};
        ntok = 2'd1;
        case (look)
          "/": begin
            if (c == "/") begin
              mode_next = sts_pkg::M_COMMENT; used = 1'b1; ntok = 2'd0;
            end else t.kind = sts_pkg::K_SLASH;
          end
          "&": begin
            if (c == "&") begin t.kind = sts_pkg::K_AND; used = 1'b1; end
            else t.kind = sts_pkg::K_REF;
          end
          "|": begin
            if (c == "|") begin t.kind = sts_pkg::K_OR; used = 1'b1; end
            else begin t.kind = sts_pkg::K_ERROR; t.err = sts_pkg::E_UNEXPECTED; end
          end
          "!": begin
            if (c == "=") begin t.kind = sts_pkg::K_BANG_EQ; used = 1'b1; end
            else t.kind = sts_pkg::K_BANG;
          end
          "=": begin
            if (c == "=") begin t.kind = sts_pkg::K_EQ_EQ; used = 1'b1; end
            else t.kind = sts_pkg::K_EQ;
          end
          "<": begin
            if (c == "=") begin t.kind = sts_pkg::K_LT_EQ; used = 1'b1; end
            else t.kind = sts_pkg::K_LT;
          end
          default: begin
            if (c == "=") begin t.kind = sts_pkg::K_GT_EQ; used = 1'b1; end
            else t.kind = sts_pkg::K_GT;
          end
        endcase
        if (used && look != "/") begin
          t.len = LENGTH_BITS'(2);
          mode_next = sts_pkg::M_IDLE;
        end
        tok[0] = t;
      end
      sts_pkg::M_COMMENT: begin
        if (c != 8'h0a && c != 8'd0) used = 1'b1;
      end
      sts_pkg::M_TICK: begin
        if (c == 8'd0) begin
          tok[0] = '{sts_pkg::K_ERROR, tstart, LENGTH_BITS'(1), line,
                     sts_pkg::E_NO_CLOSE, 1'b0};
          ntok = 2'd1;
        end else begin
          mode_next = sts_pkg::M_TICK_BYTE; length_next = LENGTH_BITS'(2); used = 1'b1;
        end
      end
      sts_pkg::M_TICK_BYTE: begin
        if (c == "'") begin
          tok[0] = '{sts_pkg::K_CHARLIT, tstart, LENGTH_BITS'(2), line,
                     sts_pkg::E_NONE, 1'b0};
          mode_next = sts_pkg::M_IDLE;
          used = 1'b1;
        end else begin
          tok[0] = '{sts_pkg::K_ERROR, tstart, LENGTH_BITS'(2), line,
                     sts_pkg::E_NO_CLOSE, 1'b0};
        end
        ntok = 2'd1;
      end
      default: ;
    endcase

    // fresh scan of the byte from idle
    if (!used) begin
      mode_next = sts_pkg::M_IDLE;
      t = '{sts_pkg::K_ERROR, offset, LENGTH_BITS'(1), line_next,
            sts_pkg::E_NONE, 1'b0};
      if (c == 8'd0) begin
        t.kind = sts_pkg::K_END; t.len = '0;
        tok[ntok] = t; ntok = ntok + 2'd1;
        ended = 1'b1;
      end else if (is_letter(c)) begin
        mode_next = sts_pkg::M_WORD; tstart_next = offset;
        length_next = LENGTH_BITS'(1); pfx_we = 1'b1; pfx_addr = 3'd0;
      end else if (is_digit(c)) begin
        mode_next = sts_pkg::M_WHOLE; tstart_next = offset; length_next = LENGTH_BITS'(1);
      end else begin
        case (c) inside
          " ", 8'h0d, 8'h09: ;
          8'h0a: if (line_next < LINE_MAX) line_next = line_next + LINE_ONE;
          "\"": begin
            mode_next = sts_pkg::M_QUOTED; tstart_next = offset;
            length_next = LENGTH_BITS'(1);
          end
          "'": begin
            mode_next = sts_pkg::M_TICK; tstart_next = offset;
            length_next = LENGTH_BITS'(1);
          end
          "/", "&", "|", "!", "=", "<", ">": begin
            mode_next = sts_pkg::M_OPER; look_next = c; tstart_next = offset;
            length_next = LENGTH_BITS'(1);
          end
          default: begin
            case (c)
              "(": t.kind = sts_pkg::K_LPAREN;
              ")": t.kind = sts_pkg::K_RPAREN;
              "{": t.kind = sts_pkg::K_LBRACE;
              "}": t.kind = sts_pkg::K_RBRACE;
              ";": t.kind = sts_pkg::K_SEMI;
              ",": t.kind = sts_pkg::K_COMMA;
              ".": t.kind = sts_pkg::K_DOT;
              "-": t.kind = sts_pkg::K_MINUS;
              "+": t.kind = sts_pkg::K_PLUS;
              "*": t.kind = sts_pkg::K_STAR;
              default: begin t.kind = sts_pkg::K_ERROR; t.err = sts_pkg::E_UNEXPECTED; end
            endcase
            tok[ntok] = t; ntok = ntok + 2'd1;
          end
        endcase
      end
    end

    // last beat of the run is flagged
    if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;

    if (ended) begin
      offset_next = '0;
      line_next   = LINE_ONE;
      mode_next   = sts_pkg::M_IDLE;
      length_next = '0;
    end else begin
      offset_next = offset + OFFSET_BITS'(1);
    end
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= sts_pkg::M_IDLE;
      look   <= '0;
      tstart <= '0;
      offset <= '0;
      line   <= LINE_ONE;
      length <= '0;
    end else if (accept_in) begin
      mode   <= mode_next;
      look   <= look_next;
      tstart <= tstart_next;
      offset <= offset_next;
      line   <= line_next;
      length <= length_next;
    end
  end

  // identifier prefix store, no reset: entries are written before they are read
  always_ff @(posedge clk) begin
    if (accept_in && pfx_we) prefix[pfx_addr] <= source_byte;
  end

  // output queue: room for three new beats plus one held beat
  always_ff @(posedge clk) begin
    if (accept_in) begin
      for (int k = 0; k < sts_pkg::MAX_TOKENS; k++) begin
        if (2'(k) < ntok) queue[wptr + 2'(k)] <= tok[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept_in) wptr <= wptr + ntok;
      if (accept_out) rptr <= rptr + 2'd1;
      count <= count + (accept_in ? {1'b0, ntok} : 3'd0) - (accept_out ? 3'd1 : 3'd0);
    end
  end

  assign token_kind   = queue[rptr].kind;
  assign token_start  = queue[rptr].start;
  assign token_length = queue[rptr].len;
  assign line_number  = queue[rptr].line;
  assign error_code   = queue[rptr].err;
  assign last_of_run  = queue[rptr].last;

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4) else $error("output queue overflow");

  // at most three beats per byte
  a_ntok: assert property (@(posedge clk) disable iff (rst)
    accept_in |-> ntok <= 2'd3) else $error("too many beats per byte");

  // offset returns to zero after end of source
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept_in && source_byte == 8'd0) |=> (offset == '0 && line == LINE_ONE))
    else $error("end of source did not restart counters");

endmodule
